FILE: sv/scl_pkg.sv
// ----------------------------------------------------------------------------
// scl_pkg
// Types, token codes, lexer modes and character constants for the shell
// command lexer.
// ----------------------------------------------------------------------------
package scl_pkg;

  typedef enum logic [3:0] {
    K_CHAR = 4'd0,
    K_WEND = 4'd1,
    K_PIPE = 4'd2,
    K_IN   = 4'd3,
    K_OUT  = 4'd4,
    K_APP  = 4'd5,
    K_ERR  = 4'd6,
    K_BG   = 4'd7,
    K_LEND = 4'd8
  } tok_kind_t;

  typedef enum logic [3:0] {
    M_PLAIN   = 4'd0,
    M_PEND_GT = 4'd1,
    M_PEND_2  = 4'd2,
    M_SQUOTE  = 4'd3,
    M_DQUOTE  = 4'd4,
    M_DQ_BS   = 4'd5,
    M_BS      = 4'd6,
    M_COMMENT = 4'd7
  } lex_mode_t;

  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam int unsigned MAX_RES = 3;

  typedef struct packed {
    logic [MAX_RES-1:0][3:0] kind;
    logic [MAX_RES-1:0][7:0] chr;
    logic [1:0]              cnt;
  } res_list_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic res_list_t push(res_list_t l, tok_kind_t k, logic [7:0] c);
    res_list_t r;
    r = l;
    if (l.cnt < 2'(MAX_RES)) begin
      r.kind[l.cnt] = k;
      r.chr[l.cnt]  = (k == K_CHAR) ? c : 8'd0;
      r.cnt         = l.cnt + 2'd1;
    end
    return r;
  endfunction

endpackage

FILE: sv/shell_command_lexer.sv
// ----------------------------------------------------------------------------
// shell_command_lexer
// Streaming tokenizer for shell command lines: words, quotes, escapes,
// comments and redirect / pipe / background operators.
// ----------------------------------------------------------------------------
// channel | dir | tdata                         | tlast
// s_*     | in  | [7:0] char_code               | line_end
// m_*     | out | [3:0] token_kind [11:4] char  | last_of_run
//
// An input byte is decoded in the cycle it is taken; its 0..3 tokens land in
// a three-entry result register and leave one per cycle while the output is
// ready. The next input is taken while the last token of the previous one is
// being handed off. Reset clears the mode, the word flag and the result
// count. A stalled output holds its token.
module shell_command_lexer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // line_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [3:0] token_kind, [11:4] char_value, [15:12] zero
  output logic        m_tlast    // last_of_run
);
  import scl_pkg::*;

  lex_mode_t  mode, mode_next;
  logic       word_has, word_has_next;
  res_list_t  res;
  logic       do_plain, do_dq;
  logic [7:0] c;

  logic [MAX_RES-1:0][3:0] buf_kind;
  logic [MAX_RES-1:0][7:0] buf_chr;
  logic [1:0]              buf_cnt;

  logic s_fire, m_fire;

  assign c        = s_tdata;
  assign s_fire   = s_tvalid && s_tready;
  assign m_fire   = m_tvalid && m_tready;
  assign m_tvalid = (buf_cnt != 2'd0);
  assign s_tready = (buf_cnt == 2'd0) || ((buf_cnt == 2'd1) && m_tready);
  assign m_tdata  = {4'd0, buf_chr[0], buf_kind[0]};
  assign m_tlast  = (buf_cnt == 2'd1);

  always_comb begin
    res           = '0;
    mode_next     = mode;
    word_has_next = word_has;
    do_plain      = 1'b0;
    do_dq         = 1'b0;
    if (s_tlast) begin
      case (mode)
        M_PEND_GT: begin
          res = push(res, K_OUT, 8'd0);
        end
        M_PEND_2: begin
          res = push(res, K_CHAR, CH_TWO);
          word_has_next = 1'b1;
        end
        M_DQ_BS: begin
          res = push(res, K_CHAR, CH_BSLASH);
          word_has_next = 1'b1;
        end
        default: ;
      endcase
      if (word_has_next) res = push(res, K_WEND, 8'd0);
      res           = push(res, K_LEND, 8'd0);
      mode_next     = M_PLAIN;
      word_has_next = 1'b0;
    end else begin
      case (mode)
        M_PEND_GT: begin
          if (c == CH_GT) begin
            res = push(res, K_APP, 8'd0);
            mode_next = M_PLAIN;
          end else begin
            res = push(res, K_OUT, 8'd0);
            do_plain = 1'b1;
          end
        end
        M_PEND_2: begin
          if (c == CH_GT) begin
            if (word_has_next) res = push(res, K_WEND, 8'd0);
            word_has_next = 1'b0;
            res = push(res, K_ERR, 8'd0);
            mode_next = M_PLAIN;
          end else begin
            res = push(res, K_CHAR, CH_TWO);
            word_has_next = 1'b1;
            do_plain = 1'b1;
          end
        end
        M_SQUOTE: begin
          if (c == CH_SQUOTE) begin
            mode_next = M_PLAIN;
          end else begin
            res = push(res, K_CHAR, c);
            word_has_next = 1'b1;
          end
        end
        M_DQUOTE: begin
          do_dq = 1'b1;
        end
        M_DQ_BS: begin
          mode_next = M_DQUOTE;
          word_has_next = 1'b1;
          if ((c == CH_DQUOTE) || (c == CH_BSLASH) || (c == CH_DOLLAR) || (c == CH_BTICK)) begin
            res = push(res, K_CHAR, c);
          end else begin
            res = push(res, K_CHAR, CH_BSLASH);
            do_dq = 1'b1;
          end
        end
        M_BS: begin
          res = push(res, K_CHAR, c);
          word_has_next = 1'b1;
          mode_next = M_PLAIN;
        end
        M_COMMENT: ;
        default: begin
          do_plain = 1'b1;
        end
      endcase

      if (do_dq) begin
        if (c == CH_DQUOTE) begin
          mode_next = M_PLAIN;
        end else if (c == CH_BSLASH) begin
          mode_next = M_DQ_BS;
        end else begin
          mode_next = M_DQUOTE;
          res = push(res, K_CHAR, c);
          word_has_next = 1'b1;
        end
      end

      if (do_plain) begin
        mode_next = M_PLAIN;
        if (is_space(c) || (c == CH_PIPE) || (c == CH_LT) || (c == CH_AMP) ||
            (c == CH_GT) || (c == CH_HASH)) begin
          if (word_has_next) res = push(res, K_WEND, 8'd0);
          word_has_next = 1'b0;
        end
        if (is_space(c)) begin
        end else if (c == CH_PIPE) begin
          res = push(res, K_PIPE, 8'd0);
        end else if (c == CH_LT) begin
          res = push(res, K_IN, 8'd0);
        end else if (c == CH_AMP) begin
          res = push(res, K_BG, 8'd0);
        end else if (c == CH_GT) begin
          mode_next = M_PEND_GT;
        end else if (c == CH_HASH) begin
          mode_next = M_COMMENT;
        end else if (c == CH_TWO) begin
          mode_next = M_PEND_2;
        end else if (c == CH_SQUOTE) begin
          mode_next = M_SQUOTE;
        end else if (c == CH_DQUOTE) begin
          mode_next = M_DQUOTE;
        end else if (c == CH_BSLASH) begin
          mode_next = M_BS;
        end else begin
          res = push(res, K_CHAR, c);
          word_has_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_PLAIN;
      word_has <= 1'b0;
    end else if (s_fire) begin
      mode     <= mode_next;
      word_has <= word_has_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_cnt <= 2'd0;
    end else if (s_fire) begin
      buf_cnt <= res.cnt;
    end else if (m_fire) begin
      buf_cnt <= buf_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      buf_kind <= res.kind;
      buf_chr  <= res.chr;
    end else if (m_fire) begin
      buf_kind <= {4'd0, buf_kind[MAX_RES-1:1]};
      buf_chr  <= {8'd0, buf_chr[MAX_RES-1:1]};
    end
  end

endmodule

FILE: sv/scl_checker.sv
// ----------------------------------------------------------------------------
// scl_checker
// Port-level checks for the shell command lexer, bound to the top level.
// ----------------------------------------------------------------------------
module scl_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast
);
  import scl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  a_line_end_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> m_tvalid)
    else $error("line end gave no token");

  a_lend_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[3:0] == K_LEND) |-> m_tlast)
    else $error("line end token not last of run");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[3:0] != K_CHAR) |-> (m_tdata[11:4] == 8'd0))
    else $error("non-character token carries a byte");

endmodule

bind shell_command_lexer scl_checker u_scl_checker (.*);

FILE: bench/tb_shell_command_lexer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_shell_command_lexer
// Self-checking bench for the shell command lexer. A scripted run of command
// bytes hits every operator, quoting rule, escape, comment and line-end case.
// Random command lines follow. Both stream sides idle at random. Every token
// is checked against the tokens in its row or a behavioral lexer.
// ----------------------------------------------------------------------------
module tb_shell_command_lexer;
  import scl_pkg::*;

  localparam int RANDOM_ITEMS = 288;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] chr;
    logic       last;
  } tok_t;

  // scripted byte; cnt > 0 means the tokens are given in the row itself
  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
    logic [1:0] cnt;
    tok_kind_t  k0;
    logic [7:0] c0;
    tok_kind_t  k1;
    logic [7:0] c1;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        m_tlast;

  lex_mode_t   lx_mode;
  logic        lx_word;
  tok_t        run_toks[$];
  tok_t        pending_tokens[$];
  stim_row_t   script[$];
  stim_row_t   cur_row;
  bit          failed;
  bit          idle_on;
  int          quiet_cycles;
  int          sink_hold;

  shell_command_lexer uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---- behavioral lexer ----
  function automatic void put_token(tok_kind_t k, logic [7:0] c);
    tok_t t;
    t.kind = k;
    t.chr  = (k == K_CHAR) ? c : 8'd0;
    t.last = 1'b0;
    if (run_toks.size() < MAX_RES) run_toks = {run_toks, t};
  endfunction

  function automatic void put_byte(logic [7:0] c);
    put_token(K_CHAR, c);
    lx_word = 1'b1;
  endfunction

  function automatic void close_word();
    if (lx_word) put_token(K_WEND, 8'd0);
    lx_word = 1'b0;
  endfunction

  function automatic void lex_plain(logic [7:0] c);
    lx_mode = M_PLAIN;
    if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
      close_word();
    end else begin
      case (c)
        CH_PIPE: begin
          close_word();
          put_token(K_PIPE, 8'd0);
        end
        CH_LT: begin
          close_word();
          put_token(K_IN, 8'd0);
        end
        CH_AMP: begin
          close_word();
          put_token(K_BG, 8'd0);
        end
        CH_GT: begin
          close_word();
          lx_mode = M_PEND_GT;
        end
        CH_HASH: begin
          close_word();
          lx_mode = M_COMMENT;
        end
        CH_TWO:    lx_mode = M_PEND_2;
        CH_SQUOTE: lx_mode = M_SQUOTE;
        CH_DQUOTE: lx_mode = M_DQUOTE;
        CH_BSLASH: lx_mode = M_BS;
        default:   put_byte(c);
      endcase
    end
  endfunction

  function automatic void lex_dquote(logic [7:0] c);
    if (c == CH_DQUOTE) lx_mode = M_PLAIN;
    else if (c == CH_BSLASH) lx_mode = M_DQ_BS;
    else put_byte(c);
  endfunction

  function automatic void lex_item(logic [7:0] c, logic eol);
    run_toks.delete();
    if (eol) begin
      case (lx_mode)
        M_PEND_GT: put_token(K_OUT, 8'd0);
        M_PEND_2:  put_byte(CH_TWO);
        M_DQ_BS:   put_byte(CH_BSLASH);
        default: ;
      endcase
      close_word();
      put_token(K_LEND, 8'd0);
      lx_mode = M_PLAIN;
      lx_word = 1'b0;
    end else begin
      case (lx_mode)
        M_PEND_GT: begin
          if (c == CH_GT) begin
            put_token(K_APP, 8'd0);
            lx_mode = M_PLAIN;
          end else begin
            put_token(K_OUT, 8'd0);
            lex_plain(c);
          end
        end
        M_PEND_2: begin
          if (c == CH_GT) begin
            close_word();
            put_token(K_ERR, 8'd0);
            lx_mode = M_PLAIN;
          end else begin
            put_byte(CH_TWO);
            lex_plain(c);
          end
        end
        M_SQUOTE: begin
          if (c == CH_SQUOTE) lx_mode = M_PLAIN;
          else put_byte(c);
        end
        M_DQUOTE: lex_dquote(c);
        M_DQ_BS: begin
          lx_mode = M_DQUOTE;
          if (c == CH_DQUOTE || c == CH_BSLASH || c == CH_DOLLAR || c == CH_BTICK) begin
            put_byte(c);
          end else begin
            put_byte(CH_BSLASH);
            lex_dquote(c);
          end
        end
        M_BS: begin
          put_byte(c);
          lx_mode = M_PLAIN;
        end
        M_COMMENT: ;
        default: lex_plain(c);
      endcase
    end
    if (run_toks.size() > 0) run_toks[run_toks.size() - 1].last = 1'b1;
  endfunction

  // ---- stimulus helpers ----
  function automatic stim_row_t pred_row(logic [7:0] ch, logic eol);
    stim_row_t r;
    r.ch  = ch;
    r.eol = eol;
    r.cnt = 2'd0;
    r.k0  = K_CHAR;
    r.c0  = 8'd0;
    r.k1  = K_CHAR;
    r.c1  = 8'd0;
    return r;
  endfunction

  function automatic stim_row_t typed_row(logic [7:0] ch, logic eol, logic [1:0] cnt,
                                          tok_kind_t k0, logic [7:0] c0,
                                          tok_kind_t k1, logic [7:0] c1);
    stim_row_t r;
    r.ch  = ch;
    r.eol = eol;
    r.cnt = cnt;
    r.k0  = k0;
    r.c0  = c0;
    r.k1  = k1;
    r.c1  = c1;
    return r;
  endfunction

  function automatic void add_row(stim_row_t r);
    script = {script, r};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 8'h61 + 8'($urandom_range(0, 25));
    if (r < 60) begin
      case ($urandom_range(0, 11))
        0:  return CH_PIPE;
        1:  return CH_LT;
        2:  return CH_GT;
        3:  return CH_GT;
        4:  return CH_AMP;
        5:  return CH_HASH;
        6:  return CH_TWO;
        7:  return CH_SQUOTE;
        8:  return CH_DQUOTE;
        9:  return CH_BSLASH;
        10: return CH_DOLLAR;
        default: return CH_BTICK;
      endcase
    end
    if (r < 66) return CH_SPACE;
    if (r < 72) return 8'($urandom_range(CH_TAB, CH_CR));
    if (r < 80) return 8'h30 + 8'($urandom_range(0, 9));
    return 8'($urandom_range(0, 255));
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(stim_row_t r);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= r.ch;
    s_tlast  <= r.eol;
    cur_row  <= r;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // ---- output side ----
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_hold = 0;
    end else if (sink_hold > 0) begin
      m_tready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else begin
      m_tready <= 1'b1;
      sink_hold = pick_gap();
    end
  end

  // ---- prediction, checking and watchdog ----
  always @(posedge clk) begin : check_blk
    tok_t want;
    if (!rst && s_tvalid && s_tready) begin
      lex_item(cur_row.ch, cur_row.eol);
      if (cur_row.cnt != 2'd0) begin
        want.kind = cur_row.k0;
        want.chr  = cur_row.c0;
        want.last = (cur_row.cnt == 2'd1);
        pending_tokens = {pending_tokens, want};
        if (cur_row.cnt == 2'd2) begin
          want.kind = cur_row.k1;
          want.chr  = cur_row.c1;
          want.last = 1'b1;
          pending_tokens = {pending_tokens, want};
        end
      end else begin
        pending_tokens = {pending_tokens, run_toks};
      end
    end
    if (!rst && m_tvalid && m_tready) begin
      if (pending_tokens.size() == 0) begin
        $error("unexpected token: token_kind %0d char_value %0d", m_tdata[3:0], m_tdata[11:4]);
        failed = 1'b1;
      end else begin
        want = pending_tokens.pop_front();
        if (m_tdata[3:0] !== want.kind) begin
          $error("token_kind: expected %0d, got %0d", want.kind, m_tdata[3:0]);
          failed = 1'b1;
        end
        if (m_tdata[11:4] !== want.chr) begin
          $error("char_value: expected %0d, got %0d", want.chr, m_tdata[11:4]);
          failed = 1'b1;
        end
        if (m_tlast !== want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, m_tlast);
          failed = 1'b1;
        end
      end
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---- main sequence ----
  initial begin : main_blk
    int  sent;
    bit  paused;
    s_tvalid     = 1'b0;
    s_tdata      = 8'd0;
    s_tlast      = 1'b0;
    rst          = 1'b1;
    failed       = 1'b0;
    idle_on      = 1'b0;
    quiet_cycles = 0;
    lx_mode      = M_PLAIN;
    lx_word      = 1'b0;
    cur_row      = pred_row(8'd0, 1'b0);

    add_row(typed_row(8'h00, 1'b1, 2'd1, K_LEND, 8'd0, K_CHAR, 8'd0));
    add_row(typed_row(8'hFF, 1'b0, 2'd1, K_CHAR, 8'hFF, K_CHAR, 8'd0));
    add_row(typed_row(8'h00, 1'b0, 2'd1, K_CHAR, 8'h00, K_CHAR, 8'd0));
    add_row(typed_row(CH_TAB, 1'b0, 2'd1, K_WEND, 8'd0, K_CHAR, 8'd0));
    add_row(typed_row(CH_PIPE, 1'b0, 2'd1, K_PIPE, 8'd0, K_CHAR, 8'd0));
    add_row(typed_row(CH_LT, 1'b0, 2'd1, K_IN, 8'd0, K_CHAR, 8'd0));
    add_row(typed_row(CH_AMP, 1'b0, 2'd1, K_BG, 8'd0, K_CHAR, 8'd0));
    add_row(pred_row(CH_GT, 1'b0));
    add_row(typed_row(CH_GT, 1'b0, 2'd1, K_APP, 8'd0, K_CHAR, 8'd0));
    // single > resolved by a high byte
    add_row(pred_row(CH_GT, 1'b0));
    add_row(pred_row(8'h80, 1'b0));
    // 2> right after a word
    add_row(pred_row(CH_TWO, 1'b0));
    add_row(pred_row(CH_GT, 1'b0));
    // double quotes: escaped $, kept backslash, backslash left at line end
    add_row(pred_row(CH_DQUOTE, 1'b0));
    add_row(pred_row(CH_BSLASH, 1'b0));
    add_row(pred_row(CH_DOLLAR, 1'b0));
    add_row(pred_row(CH_BSLASH, 1'b0));
    add_row(pred_row(8'h71, 1'b0));
    add_row(pred_row(CH_BSLASH, 1'b0));
    add_row(pred_row(8'h00, 1'b1));
    // empty quotes, escaped #, then a comment
    add_row(pred_row(CH_SQUOTE, 1'b0));
    add_row(pred_row(CH_SQUOTE, 1'b0));
    add_row(pred_row(CH_BSLASH, 1'b0));
    add_row(pred_row(CH_HASH, 1'b0));
    add_row(pred_row(CH_HASH, 1'b0));
    add_row(pred_row(CH_GT, 1'b0));
    add_row(pred_row(8'h00, 1'b1));
    // dangling backslash, > and 2 at line end
    add_row(pred_row(CH_BSLASH, 1'b0));
    add_row(pred_row(8'h00, 1'b1));
    add_row(pred_row(CH_GT, 1'b0));
    add_row(pred_row(8'h00, 1'b1));
    add_row(pred_row(CH_TWO, 1'b0));
    add_row(pred_row(8'h00, 1'b1));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) send_item(script[i]);

    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 32 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        // drain the token pipe completely before going on
        paused = 1'b1;
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_tokens.size() != 0) @(negedge clk);
      end
      if ($urandom_range(0, 9) == 0) send_item(pred_row(8'($urandom_range(0, 255)), 1'b1));
      else send_item(pred_row(pick_char(), 1'b0));
      sent = sent + 1;
    end
    s_tvalid <= 1'b0;

    while (pending_tokens.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (!failed) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

FILE: files.f
sv/scl_pkg.sv
sv/shell_command_lexer.sv
sv/scl_checker.sv
bench/tb_shell_command_lexer.sv
